/* src/stack_with_max_scan_core_defines.svh */
// Assertion macros used by the stack core top level.
`ifndef STACK_WITH_MAX_SCAN_CORE_DEFINES_SVH
`define STACK_WITH_MAX_SCAN_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sws: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sws: next-cycle check failed");

`endif

/* src/sws_pkg.sv */
// Types and constants of the stack core with maximum scan.
package sws_pkg;

  localparam int DATA_W  = 32;
  localparam int MAX_W   = 31;
  localparam int FIELD_W = 9;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_MAX   = 2'd3
  } cmd_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Per-cell control: push shifts down, shift_up moves towards the top,
  // wrap makes the cell take the top value during a rotation
  typedef struct packed {
    logic push;
    logic shift_up;
    logic wrap;
  } cell_ctrl_t;

endpackage

/* src/sws_in_if.sv */
// Command channel: valid/ready handshake with command and value.
interface sws_in_if;
  import sws_pkg::*;

  logic                     valid;
  logic                     ready;
  cmd_t                     cmd;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

/* src/sws_out_if.sv */
// Result channel: valid/ready handshake with status, values and counts.
interface sws_out_if;
  import sws_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] popped_value;
  logic [MAX_W-1:0]         max_value;
  logic [FIELD_W-1:0]       max_position;
  logic [FIELD_W-1:0]       entry_count;

  modport source (output valid, output status, output popped_value, output max_value,
                  output max_position, output entry_count, input ready);
  modport sink   (input valid, input status, input popped_value, input max_value,
                  input max_position, input entry_count, output ready);
endinterface

/* src/sws_cell.sv */
// One stack cell: holds one entry and trades it with its neighbours.
module sws_cell (
  input  logic                        clk,
  input  sws_pkg::cell_ctrl_t         ctrl,
  input  logic [sws_pkg::DATA_W-1:0]  up_data,
  input  logic [sws_pkg::DATA_W-1:0]  down_data,
  input  logic [sws_pkg::DATA_W-1:0]  top_data,
  output logic [sws_pkg::DATA_W-1:0]  data_q
);
  import sws_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Push takes from above; pop and rotation take from below, or from the
  // top when this cell closes the rotation ring
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = up_data;
    end else if (ctrl.shift_up) begin
      data_nxt = ctrl.wrap ? top_data : down_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

/* src/stack_with_max_scan_core.sv */
// Top level of the stack core: cell chain, controller and result register.
`include "stack_with_max_scan_core_defines.svh"

// LIFO stack of STACK_DEPTH signed 32-bit entries built as a chain of cells, cell 0
// being the top. For push, pop and clear the word is accepted and its result is
// loaded into the output register in the same edge, so these commands run back to
// back while the result side keeps taking words. For find maximum the chain rotates
// its filled part one cell per cycle past a single comparator at the top, and the
// input stays stalled until the rotation has restored the original order. A new word
// is taken once the output register is empty or is being read in the same cycle. The
// stack contents are undefined after reset; only the entry count, the state and the
// output valid are cleared, so there is no clearing pass. A push on a full stack is
// refused with status full; a pop on an empty stack reports empty.
// Counts are given on 9 bits, masked when STACK_DEPTH exceeds 511.
module stack_with_max_scan_core #(
  parameter int STACK_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  sws_in_if.sink    in_ch,
  sws_out_if.source out_ch
);
  import sws_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Zero-extend or truncate a count to the 9-bit result fields
  function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            step_r, step_nxt;
  logic signed [DATA_W-1:0] run_r, run_nxt;
  logic [CW-1:0]            best_pos_r, best_pos_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_popped_r, out_popped_nxt;
  logic [MAX_W-1:0]         out_max_r, out_max_nxt;
  logic [FIELD_W-1:0]       out_pos_r, out_pos_nxt;
  logic [FIELD_W-1:0]       out_count_r, out_count_nxt;

  logic                     in_ready;
  logic                     in_acc;
  logic                     push_ok;
  logic                     pop_ok;
  logic                     rotate;
  logic                     scan_last;
  logic                     scan_better;
  logic signed [DATA_W-1:0] top_val;
  logic signed [DATA_W-1:0] run_new;
  logic [CW-1:0]            pos_new;

  logic [DATA_W-1:0]        cell_q [STACK_DEPTH];
  cell_ctrl_t               cell_ctrl [STACK_DEPTH];

  // Handshake
  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign push_ok = in_acc && (in_ch.cmd == CMD_PUSH) && (count_r != CW'(STACK_DEPTH));
  assign pop_ok  = in_acc && (in_ch.cmd == CMD_POP) && (count_r != '0);
  assign rotate  = (state_r == S_SCAN);

  // Scan comparator at the top of the chain
  assign top_val     = $signed(cell_q[0]);
  assign scan_better = top_val > run_r;
  assign run_new     = scan_better ? top_val : run_r;
  assign pos_new     = scan_better ? (step_r + CW'(1)) : best_pos_r;
  assign scan_last   = rotate && ((step_r + CW'(1)) == count_r);

  // Cell chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic [DATA_W-1:0] down_d;

    if (i == 0) begin : g_top
      assign up_d = in_ch.push_value;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_d = '0;
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end

    // The last filled cell closes the ring during a rotation
    assign cell_ctrl[i].push     = push_ok;
    assign cell_ctrl[i].shift_up = pop_ok || rotate;
    assign cell_ctrl[i].wrap     = rotate && (count_r == CW'(i + 1));

    sws_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .up_data   (up_d),
      .down_data (down_d),
      .top_data  (cell_q[0]),
      .data_q    (cell_q[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.cmd == CMD_MAX) && (count_r != '0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result register
  always_comb begin
    count_nxt      = count_r;
    step_nxt       = step_r;
    run_nxt        = run_r;
    best_pos_nxt   = best_pos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    out_max_nxt    = out_max_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;

    if (in_acc) begin
      out_status_nxt = ST_OK;
      out_popped_nxt = '0;
      out_max_nxt    = '0;
      out_pos_nxt    = '0;
      case (in_ch.cmd)
        CMD_PUSH: begin
          if (push_ok) begin
            count_nxt = count_r + CW'(1);
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
        CMD_POP: begin
          if (pop_ok) begin
            count_nxt      = count_r - CW'(1);
            out_popped_nxt = top_val;
          end else begin
            out_status_nxt = ST_EMPTY;
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: begin
          step_nxt     = '0;
          run_nxt      = '0;
          best_pos_nxt = '0;
        end
      endcase
      out_count_nxt = to_field(count_nxt);
      // An empty find maximum answers at once; otherwise the scan answers
      out_valid_nxt = !((in_ch.cmd == CMD_MAX) && (count_r != '0));
    end

    if (rotate) begin
      step_nxt     = step_r + CW'(1);
      run_nxt      = run_new;
      best_pos_nxt = pos_new;
      if (scan_last) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_popped_nxt = '0;
        out_max_nxt    = run_new[MAX_W-1:0];
        out_pos_nxt    = to_field(pos_new);
        out_count_nxt  = to_field(count_r);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    run_r        <= run_nxt;
    best_pos_r   <= best_pos_nxt;
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_max_r    <= out_max_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.max_value    = out_max_r;
  assign out_ch.max_position = out_pos_r;
  assign out_ch.entry_count  = out_count_r;

  // Checks
  `SWS_ASSERT_IMP(a_no_take_in_scan, state_r == S_SCAN, !in_ch.ready)
  `SWS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(STACK_DEPTH))
  `SWS_ASSERT_NXT(a_push_grows, push_ok, count_r == $past(count_r) + CW'(1))
  `SWS_ASSERT_NXT(a_scan_starts,
                  in_acc && (in_ch.cmd == CMD_MAX) && (count_r != '0),
                  (state_r == S_SCAN) && !out_valid_r)
  `SWS_ASSERT_IMP(a_scan_in_range, state_r == S_SCAN, step_r < count_r)

endmodule
